// ----- design/sha256_pkg.sv -----
// Package for the SHA-256 message hasher: round constants, initial hash
// values and the round helper functions. No dependencies.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [31:0] word_t;

  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_word(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  // Handshake between the top level and the round unit.
  typedef struct packed {
    logic start;
    logic done;
  } rnd_ctl_t;

endpackage

// ----- design/sha256_round.sv -----
// One SHA-256 round unit, used 64 times per block, with its schedule window.
// Depends on sha256_pkg.
module sha256_round
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  word_t       blk_word,   // message word r during rounds 0..15
  input  word_t [7:0] h_in,
  output logic [3:0]  rd_idx,     // block word for the current round
  output word_t [7:0] v_out,
  output logic        done
);

  word_t [15:0] w_r;
  word_t [7:0]  v_r;
  logic [5:0]   rnd_r;
  logic         busy_r;
  logic         done_r;

  word_t wt, s0, s1, wnew, t1, t2;

  assign rd_idx = rnd_r[3:0];

  always_comb begin
    s0   = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    wt   = (rnd_r < 6'd16) ? blk_word : wnew;
    t1   = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_const(rnd_r) + wt;
    t2   = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        v_r    <= h_in;
      end else if (busy_r) begin
        v_r    <= {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
        w_r    <= {wt, w_r[15:1]};
        rnd_r  <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign v_out = v_r;
  assign done  = done_r;

endmodule

// ----- design/sha256_message_hasher_core.sv -----
// Top level of the SHA-256 message hasher. Holds the block buffer, the
// chaining words, the sequencer and the output register. Uses sha256_pkg
// and sha256_round.
//
// A word with in_mode 0 absorbs in_data_byte, and in_ready stays high for the
// next word except after the 64th byte of a block. That byte starts a
// compression of 64 rounds followed by the chaining update, and in_ready is
// low until both are done. A word with in_mode 1 pads the message and
// compresses one or two blocks. The sequencer writes the zero bytes and then
// the length bytes into the buffer before the last compression; two blocks
// are needed when fewer than eight bytes follow the 0x80. The digest then
// comes out as eight output words, word_index 0 first, last_word set on the
// eighth. After the chaining update of the last compression the sequencer
// loads the first word into the output register, and the rest follow one
// per cycle while out_ready is high. in_ready stays low from the finish word
// until the eighth word is taken. After the digest the hasher starts over
// from the initial hash values. The single round unit, one round per cycle,
// sets the throughput.
module sha256_message_hasher_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] StIdle = 3'd0;  // accept words
  localparam logic [2:0] StPad  = 3'd1;  // write padding bytes
  localparam logic [2:0] StLen  = 3'd2;  // write length bytes
  localparam logic [2:0] StComp = 3'd3;  // waiting on round unit
  localparam logic [2:0] StOut  = 3'd4;  // delivering digest

  logic [2:0]   st_r;
  logic [60:0]  byte_cnt_r;   // bytes absorbed; bit count is this times 8
  logic [63:0]  len_r;        // latched bit length for padding
  logic [5:0]   pos_r;        // padding write pointer
  logic         final_r;      // compression in flight is the last block
  logic         extra_r;      // padding needs a second block after this one
  word_t [7:0]  h_r;
  logic [2:0]   oidx_r;
  logic         oval_r;
  word_t        odat_r;

  // Block buffer as 16 words of 4 bytes, at most one byte written per cycle.
  logic [3:0][7:0] mem_r [16];
  word_t        blk_word;
  logic [3:0]   rd_idx;
  word_t [7:0]  v_out;
  rnd_ctl_t     rc;
  logic         rnd_done;

  logic         wr_en;
  logic [5:0]   wr_addr;
  logic [7:0]   wr_data;

  assign blk_word = mem_r[rd_idx];

  sha256_round u_round (
    .clk, .rst_n,
    .start    (rc.start),
    .blk_word (blk_word),
    .h_in     (h_r),
    .rd_idx   (rd_idx),
    .v_out    (v_out),
    .done     (rnd_done)
  );

  assign in_ready = (st_r == StIdle);
  wire in_acc = in_valid && in_ready;
  wire [5:0] fill = byte_cnt_r[5:0];

  // Any byte written to the last slot of a block (data, pad, zero or length) starts a compression at once.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill;
    wr_data = in_data_byte;
    rc.start = 1'b0;
    rc.done  = rnd_done;
    if (in_acc) begin
      wr_en   = 1'b1;
      wr_data = in_mode ? PadByte : in_data_byte;
      rc.start = (fill == 6'd63);
    end else if (st_r == StPad || st_r == StLen) begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = (st_r == StLen) ? len_r[8'd63 - {pos_r[2:0], 3'd0} -: 8] : 8'h00;
      rc.start = (pos_r == 6'd63);
    end
  end

  // Byte 0 of a word is its most significant byte.
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr[5:2]][2'd3 - wr_addr[1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= StIdle;
      byte_cnt_r <= '0;
      final_r    <= 1'b0;
      extra_r    <= 1'b0;
      oval_r     <= 1'b0;
      oidx_r     <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_word(3'(i));
    end else begin
      unique case (st_r)
        StIdle: begin
          if (in_acc) begin
            final_r <= 1'b0;
            if (!in_mode) begin
              byte_cnt_r <= byte_cnt_r + 61'd1;
              if (fill == 6'd63) st_r <= StComp;
            end else begin
              len_r   <= {byte_cnt_r, 3'd0};
              pos_r   <= fill + 6'd1;
              // No room for the length after the pad byte: two blocks.
              extra_r <= (fill > LenPos - 6'd1);
              if (fill == 6'd63) st_r <= StComp;
              else if (fill == LenPos - 6'd1) st_r <= StLen;
              else st_r <= StPad;
            end
          end
        end
        StPad: begin
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            st_r <= StComp;   // padding overflowed into a second block
          end else if (pos_r == LenPos - 6'd1) begin
            st_r <= StLen;
          end
        end
        StLen: begin
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            st_r    <= StComp;
            final_r <= 1'b1;
          end
        end
        StComp: begin
          if (rc.done) begin
            for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_out[i];
            if (final_r) begin
              st_r   <= StOut;
              oidx_r <= '0;
            end else if (extra_r) begin
              st_r    <= StPad;   // second padding block, pos_r is back at 0
              extra_r <= 1'b0;
            end else begin
              st_r <= StIdle;
            end
          end
        end
        StOut: begin
          if (!oval_r || out_ready) begin
            if (oval_r && oidx_r == 3'd7) begin
              oval_r     <= 1'b0;
              st_r       <= StIdle;
              byte_cnt_r <= '0;
              len_r      <= '0;
              final_r    <= 1'b0;
              for (int i = 0; i < 8; i++) h_r[i] <= init_word(3'(i));
            end else begin
              if (oval_r) oidx_r <= oidx_r + 3'd1;
              odat_r <= h_r[oval_r ? oidx_r + 3'd1 : oidx_r];
              oval_r <= 1'b1;
            end
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_valid       = oval_r;
  assign out_digest_word = odat_r;
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during digest");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> !out_valid)
    else $error("extra digest word");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rc.start |-> (st_r != StComp)) else $error("round unit restarted");

endmodule

// ----- verif/tb_sha256_message_hasher_core.sv -----
// Self-checking testbench for sha256_message_hasher_core: drives absorb and
// finish words, predicts each digest with its own SHA-256 model and compares
// every output word. Depends on sha256_pkg and the core RTL.
module tb_sha256_message_hasher_core
  import sha256_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Input word modes.
  typedef enum logic {
    ModeAbsorb = 1'b0,
    ModeFinish = 1'b1
  } hash_mode_e;

  // One expected output word.
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  // One row of the directed stimulus. When has_digest is set, the first and
  // last digest words of the finish are typed in from known vectors as well.
  typedef struct {
    hash_mode_e  mode;
    logic [7:0]  data;
    logic        has_digest;
    logic [31:0] first_word;
    logic [31:0] final_word;
  } stim_row_t;

  localparam int unsigned ClockLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_message_hasher_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  // Predictor state: a private copy of the chaining words, the block buffer
  // and the 64-bit message length in bits.
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_bits;

  digest_out_t digest_queue [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        hold_off_req;
  logic        directed_done;

  // Clock generation: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard limit so that a hung block cannot stall the run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > ClockLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Standard 64-round compression of msg_block into hash_state.
  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    begin
      for (int r = 0; r < 16; r++)
        w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (int r = 16; r < 64; r++) begin
        s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
        s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
        w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int r = 0; r < 64; r++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + round_const(r[5:0]) + w[r];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    end
  endtask

  task automatic restart_hash_state();
    begin
      for (int i = 0; i < 8; i++) hash_state[i] = init_word(i[2:0]);
      msg_bits = '0;
    end
  endtask

  // Applies one accepted input word to the predictor. A finish pads the
  // message, compresses one or two blocks and queues the eight digest words.
  task automatic hash_predict(input hash_mode_e mode, input logic [7:0] data);
    int pos;
    digest_out_t dw;
    begin
      pos = int'(msg_bits[8:3]);
      if (mode == ModeAbsorb) begin
        msg_block[pos] = data;
        msg_bits += 64'd8;
        if (pos == 63) compress_msg_block();
      end else begin
        msg_block[pos] = PadByte;
        pos++;
        // No room left for the length: the padding spills into an extra block.
        if (pos > int'(LenPos)) begin
          while (pos < 64) begin
            msg_block[pos] = 8'h00;
            pos++;
          end
          compress_msg_block();
          pos = 0;
        end
        while (pos < int'(LenPos)) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
        compress_msg_block();
        for (int i = 0; i < 8; i++) begin
          dw.digest_word = hash_state[i];
          dw.word_index  = i[2:0];
          dw.last_word   = (i == 7);
          digest_queue.push_back(dw);
        end
        restart_hash_state();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
    end
  endtask

  // Output checker: each accepted output word is compared with the oldest
  // expected digest word.
  always @(posedge clk) begin
    digest_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected word", out_digest_word, 32'h0);
      end else begin
        want = digest_queue.pop_front();
        if (out_digest_word !== want.digest_word)
          report_mismatch("digest_word", out_digest_word, want.digest_word);
        if (out_word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_word_index), 32'(want.word_index));
        if (out_last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_last_word), 32'(want.last_word));
      end
    end
  end

  // Receiver: during the directed part it stalls now and then, later it runs
  // a random pattern, and on request it holds
  // off for a long stretch so that the core fills up and stalls its input.
  initial begin
    int unsigned stall_cnt;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        stall_cnt = 600;
        while (stall_cnt > 0) begin
          @(posedge clk);
          stall_cnt--;
        end
        hold_off_req = 1'b0;
      end else if (!directed_done) begin
        out_ready <= ($urandom_range(3) != 0);
      end else begin
        case ($urandom_range(3))
          0: out_ready <= 1'b1;
          1: out_ready <= 1'b0;
          default: out_ready <= ($urandom_range(1) == 1);
        endcase
      end
    end
  end

  // Offers one word and holds it until accepted, then updates the predictor.
  task automatic send_word(input hash_mode_e mode, input logic [7:0] data);
    begin
      in_valid     <= 1'b1;
      in_mode      <= mode;
      in_data_byte <= data;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      hash_predict(mode, data);
    end
  endtask

  // Inserts a random gap between bursts of random length; valid is lowered
  // only when the drawn gap is not zero.
  task automatic maybe_gap(inout int burst_left);
    int gap;
    begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(20);
      end
    end
  endtask

  task automatic wait_digests_done();
    begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (digest_queue.size() != 0) @(posedge clk);
    end
  endtask

  stim_row_t directed_rows [$];

  initial begin
    int burst_left;
    int msg_len;
    int sent;
    logic hold_done;
    logic drain_done;
    stim_row_t row;
    digest_out_t first_want;
    digest_out_t final_want;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = ModeAbsorb;
    in_data_byte   = 8'h00;
    hold_off_req   = 1'b0;
    directed_done  = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    sent           = 0;
    hold_done      = 1'b0;
    drain_done     = 1'b0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    restart_hash_state();

    // Directed table: the empty message and "abc" use known digests; then
    // byte extremes 0x00 and 0xff with 0xaa and 0x55 in one message.
    directed_rows.push_back('{ModeFinish, 8'h00, 1'b1, 32'he3b0c442, 32'h7852b855});
    directed_rows.push_back('{ModeAbsorb, 8'h61, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeAbsorb, 8'h62, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeAbsorb, 8'h63, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeFinish, 8'hff, 1'b1, 32'hba7816bf, 32'hf20015ad});
    directed_rows.push_back('{ModeAbsorb, 8'h00, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeAbsorb, 8'hff, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeAbsorb, 8'haa, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeAbsorb, 8'h55, 1'b0, 32'h0, 32'h0});
    directed_rows.push_back('{ModeFinish, 8'h00, 1'b0, 32'h0, 32'h0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      send_word(row.mode, row.data);
      if (row.has_digest) begin
        // The predictor just queued this digest; check it against the vector.
        first_want = digest_queue[digest_queue.size() - 8];
        final_want = digest_queue[digest_queue.size() - 1];
        if (first_want.digest_word !== row.first_word)
          report_mismatch("known digest head", first_want.digest_word, row.first_word);
        if (final_want.digest_word !== row.final_word)
          report_mismatch("known digest tail", final_want.digest_word, row.final_word);
      end
    end
    in_valid <= 1'b0;

    // Padding boundaries: 55 bytes fits one block, 56 needs an extra block,
    // 63 puts the pad byte in the last slot of the block.
    for (int k = 0; k < 3; k++) begin
      msg_len = (k == 0) ? 55 : (k == 1) ? 56 : 63;
      for (int i = 0; i < msg_len; i++) send_word(ModeAbsorb, 8'($urandom));
      send_word(ModeFinish, 8'($urandom));
    end
    directed_done = 1'b1;

    // Random part: whole messages of random length with random bytes; sizes
    // stay short with an occasional message that crosses a block.
    while (sent < 60) begin
      msg_len = ($urandom_range(7) == 0) ? $urandom_range(70) : $urandom_range(12);
      // Long receiver hold-off once, while the sender keeps offering.
      if (!hold_done && sent >= 10) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      for (int i = 0; i < msg_len; i++) begin
        maybe_gap(burst_left);
        send_word(ModeAbsorb, 8'($urandom));
        sent++;
      end
      maybe_gap(burst_left);
      // A finish carries a random byte, which must be ignored.
      send_word(ModeFinish, 8'($urandom));
      sent++;
      // Sender pauses once until every digest has drained.
      if (!drain_done && sent >= 30) begin
        wait_digests_done();
        drain_done = 1'b1;
      end
    end

    wait_digests_done();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
